[rtl/core/gtr_pkg.sv]
// ----------------------------------------------------------------------------
// gtr_pkg: shared definitions for grid_two_edge_reachability_core
// Field widths, default sizes, opcodes, register indexes and the result word.
// ----------------------------------------------------------------------------
package gtr_pkg;

  // Default physical grid and height size
  localparam int MAX_ROWS_DEF    = 32;
  localparam int MAX_COLS_DEF    = 32;
  localparam int HEIGHT_BITS_DEF = 16;

  // Fixed port field widths
  localparam int ROW_W       = 5;
  localparam int COL_W       = 5;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_DATA_W  = 6;
  localparam int CFG_INDEX_W = 2;

  // Visit mark width; one clearing pass each time it runs out
  localparam int EPOCH_W = 8;

  // Opcodes of an input word
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COLS = 2'd1;

  // Reset value of both size registers
  localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 6'd32;

  // One result word
  typedef struct packed {
    logic pacific_reached;
    logic atlantic_reached;
    logic both_reached;
    logic out_of_range;
  } result_t;

endpackage

[rtl/core/gtr_ram.sv]
// ----------------------------------------------------------------------------
// gtr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gtr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/gtr_walk.sv]
// ----------------------------------------------------------------------------
// gtr_walk: cell store, flood walk sequencer and result register
// Grid memory holds {visit mark, height} per cell; stack memory holds the
// cells still to expand. Visit marks are compared against a query epoch.
// ----------------------------------------------------------------------------
module gtr_walk #(
  parameter int MAX_ROWS    = gtr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = gtr_pkg::MAX_COLS_DEF,
  parameter int HEIGHT_BITS = gtr_pkg::HEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_ROWS+1)-1:0]     rows_used,
  input  logic [$clog2(MAX_COLS+1)-1:0]     cols_used,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [gtr_pkg::ROW_W-1:0]         row,
  input  logic [gtr_pkg::COL_W-1:0]         col,
  input  logic [gtr_pkg::HEIGHT_W-1:0]      height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gtr_pkg::result_t                  res
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SZR   = $clog2(MAX_ROWS + 1);
  localparam int SZC   = $clog2(MAX_COLS + 1);
  localparam int SPW   = $clog2(CELLS + 1);
  localparam int EW    = gtr_pkg::EPOCH_W;
  localparam int GW    = EW + HEIGHT_BITS;
  localparam int SW    = RW + CW + HEIGHT_BITS;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SEED  = 3'd2;
  localparam logic [2:0] S_NBR   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_CLRWB = 3'd7;

  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_RIGHT = 2'd2;
  localparam logic [1:0] NB_LEFT  = 2'd3;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    cell_addr = AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  function automatic logic at_pac(input logic [RW-1:0] r, input logic [CW-1:0] c);
    at_pac = (r == '0) || (c == '0);
  endfunction

  function automatic logic at_atl(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                  input logic [SZR-1:0] nr, input logic [SZC-1:0] nc);
    at_atl = (32'(r) + 1 == 32'(nr)) || (32'(c) + 1 == 32'(nc));
  endfunction

  // Sequencer and walk registers
  logic [2:0]             state;
  logic [AW-1:0]          clr_cnt;
  logic                   clr_wb;
  logic [AW-1:0]          clr_wa;
  logic [EW-1:0]          epoch;
  logic [RW-1:0]          cur_r;
  logic [CW-1:0]          cur_c;
  logic [AW-1:0]          cur_addr;
  logic [HEIGHT_BITS-1:0] cur_h;
  logic [1:0]             k;
  logic                   pend_v;
  logic [RW-1:0]          pend_r;
  logic [CW-1:0]          pend_c;
  logic [AW-1:0]          pend_addr;
  logic [SPW-1:0]         sp;
  logic                   pac;
  logic                   atl;

  // Memory ports
  logic          grid_we, grid_re;
  logic [AW-1:0] grid_waddr, grid_raddr;
  logic [GW-1:0] grid_wdata, grid_rdata;
  logic          stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;

  // Decoded signals
  logic                   out_free;
  logic                   out_load;
  logic                   accept;
  logic                   in_phys;
  logic                   in_oor;
  logic [AW-1:0]          in_addr;
  logic [HEIGHT_BITS-1:0] h_in;
  logic [RW-1:0]          nb_r;
  logic [CW-1:0]          nb_c;
  logic                   nb_ok;
  logic [AW-1:0]          nb_addr;
  logic [EW-1:0]          g_tag;
  logic [HEIGHT_BITS-1:0] g_h;
  logic                   take;
  logic [SPW-1:0]         sp_dec;
  logic [RW-1:0]          ld_r;
  logic [CW-1:0]          ld_c;
  logic [HEIGHT_BITS-1:0] ld_h;

  gtr_ram #(.WIDTH(GW), .DEPTH(CELLS)) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .re    (grid_re),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  gtr_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Decode the input word
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign in_phys  = (32'(row) < MAX_ROWS) && (32'(col) < MAX_COLS);
  assign in_oor   = (32'(row) >= 32'(rows_used)) || (32'(col) >= 32'(cols_used));
  assign in_addr  = cell_addr(RW'(row), CW'(col));
  assign h_in     = HEIGHT_BITS'(height);

  // Load the output register for a write, an out-of-range query or a finished walk
  assign out_load = (accept && !((opcode == gtr_pkg::OP_QUERY) && !in_oor)) ||
                    ((state == S_DONE) && out_free);

  // Pick the neighbour probed this cycle
  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_ok = 1'b0;
    unique case (k)
      NB_UP: begin
        nb_r  = cur_r - RW'(1);
        nb_ok = (cur_r != '0);
      end
      NB_DOWN: begin
        nb_r  = cur_r + RW'(1);
        nb_ok = (32'(cur_r) + 1 < 32'(rows_used));
      end
      NB_RIGHT: begin
        nb_c  = cur_c + CW'(1);
        nb_ok = (32'(cur_c) + 1 < 32'(cols_used));
      end
      NB_LEFT: begin
        nb_c  = cur_c - CW'(1);
        nb_ok = (cur_c != '0);
      end
    endcase
  end
  assign nb_addr = cell_addr(nb_r, nb_c);

  // Judge the neighbour read last cycle
  assign g_tag  = grid_rdata[GW-1 -: EW];
  assign g_h    = grid_rdata[HEIGHT_BITS-1:0];
  assign take   = pend_v && (g_tag != epoch) && (g_h <= cur_h);
  assign sp_dec = sp - SPW'(1);
  assign ld_r   = stk_rdata[SW-1 -: RW];
  assign ld_c   = stk_rdata[CW+HEIGHT_BITS-1 -: CW];
  assign ld_h   = stk_rdata[HEIGHT_BITS-1:0];

  // Drive the memory ports
  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = pend_addr;
    grid_wdata = {epoch, g_h};
    grid_re    = 1'b0;
    grid_raddr = nb_addr;
    stk_we     = 1'b0;
    stk_waddr  = sp[AW-1:0];
    stk_wdata  = {pend_r, pend_c, g_h};
    stk_re     = 1'b0;
    stk_raddr  = sp_dec[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        // Read one cell, write the one read last cycle back with its mark cleared
        grid_re    = 1'b1;
        grid_raddr = clr_cnt;
        grid_we    = clr_wb;
        grid_waddr = clr_wa;
        grid_wdata = {EW'(0), g_h};
      end
      S_CLRWB: begin
        grid_we    = 1'b1;
        grid_waddr = clr_wa;
        grid_wdata = {EW'(0), g_h};
      end
      S_IDLE: begin
        grid_waddr = in_addr;
        grid_wdata = {EW'(0), h_in};
        grid_raddr = in_addr;
        grid_we    = accept && (opcode == gtr_pkg::OP_WRITE) && in_phys;
        grid_re    = accept && (opcode == gtr_pkg::OP_QUERY) && !in_oor;
      end
      S_SEED: begin
        grid_we    = 1'b1;
        grid_waddr = cur_addr;
        grid_wdata = {epoch, g_h};
      end
      S_NBR: begin
        grid_we = take;
        grid_re = nb_ok;
        stk_we  = take;
      end
      S_DRAIN: begin
        grid_we = take;
        stk_re  = !take && (sp != '0);
      end
      default: begin
      end
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      clr_wb    <= 1'b0;
      epoch     <= '0;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
      sp        <= '0;
      k         <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_wb <= 1'b1;
          clr_wa <= clr_cnt;
          if (clr_cnt == AW'(CELLS - 1)) begin
            clr_cnt <= '0;
            state   <= S_CLRWB;
          end else begin
            clr_cnt <= clr_cnt + AW'(1);
          end
        end
        S_CLRWB: begin
          clr_wb <= 1'b0;
          epoch  <= '0;
          state  <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if ((opcode == gtr_pkg::OP_QUERY) && !in_oor) begin
              epoch    <= epoch + EW'(1);
              cur_r    <= RW'(row);
              cur_c    <= CW'(col);
              cur_addr <= in_addr;
              state    <= S_SEED;
            end else begin
              res <= '{pacific_reached: 1'b0, atlantic_reached: 1'b0,
                       both_reached: 1'b0, out_of_range: in_oor};
            end
          end
        end
        S_SEED: begin
          cur_h  <= g_h;
          pac    <= at_pac(cur_r, cur_c);
          atl    <= at_atl(cur_r, cur_c, rows_used, cols_used);
          k      <= '0;
          pend_v <= 1'b0;
          sp     <= '0;
          state  <= S_NBR;
        end
        S_NBR: begin
          pend_v    <= nb_ok;
          pend_r    <= nb_r;
          pend_c    <= nb_c;
          pend_addr <= nb_addr;
          if (take) begin
            sp <= sp + SPW'(1);
          end
          k <= k + 2'd1;
          if (k == NB_LEFT) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pend_v <= 1'b0;
          k      <= '0;
          // Expand a freshly taken cell at once, without a stack round trip
          if (take) begin
            cur_r <= pend_r;
            cur_c <= pend_c;
            cur_h <= g_h;
            pac   <= pac | at_pac(pend_r, pend_c);
            atl   <= atl | at_atl(pend_r, pend_c, rows_used, cols_used);
            state <= S_NBR;
          end else if (sp != '0) begin
            sp    <= sp_dec;
            state <= S_LOAD;
          end else begin
            state <= S_DONE;
          end
        end
        S_LOAD: begin
          cur_r <= ld_r;
          cur_c <= ld_c;
          cur_h <= ld_h;
          pac   <= pac | at_pac(ld_r, ld_c);
          atl   <= atl | at_atl(ld_r, ld_c, rows_used, cols_used);
          state <= S_NBR;
        end
        S_DONE: begin
          if (out_free) begin
            res   <= '{pacific_reached: pac, atlantic_reached: atl,
                       both_reached: pac && atl, out_of_range: 1'b0};
            state <= (epoch == {EW{1'b1}}) ? S_CLEAR : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Same-cycle grid read and write never share a cell
  a_grid_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (grid_we && grid_re) |-> (grid_waddr != grid_raddr))
    else $error("grid read and write hit the same cell");

  // Stack push and pop never share a cycle
  a_stack_no_overlap: assert property (@(posedge clk) disable iff (rst)
    stk_we |-> !stk_re)
    else $error("stack push and pop in one cycle");

  // A finished query always yields a word
  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_free) |=> out_valid)
    else $error("finished query produced no word");

  // Out-of-range words carry no reach flags
  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res.out_of_range && (res.pacific_reached || res.atlantic_reached)))
    else $error("out-of-range word carries reach flags");

  // Input is only taken with a free output register
  a_accept_free: assert property (@(posedge clk) disable iff (rst)
    accept |-> ((state == S_IDLE) && (!out_valid || !out_stall)))
    else $error("input taken while output blocked");

endmodule

[rtl/core/grid_two_edge_reachability_core.sv]
// ----------------------------------------------------------------------------
// grid_two_edge_reachability_core: height grid with per-cell edge reachability
// Holds the size registers and the walk engine over the grid and stack RAMs.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | to core   | in_valid / in_stall    | opcode, row, col, height
//  out     | from core | out_valid / out_stall  | pacific/atlantic/both, range
//  cfg     | to core   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A write or an out-of-range query is answered without a walk. A query in range
// seeds its start cell, then for each cell of its region makes four neighbour probes
// and one drain step on the single grid read port, and one more step on a stack pop.
// After reset, and after every 255 queries in range, a clearing pass over all
// MAX_ROWS*MAX_COLS cells resets the visit marks and keeps the heights;
// no word is taken then.
// A stalled result holds in the output register; the next word is taken
// as soon as that register is free or being emptied.
// ----------------------------------------------------------------------------
module grid_two_edge_reachability_core #(
  parameter int MAX_ROWS    = gtr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = gtr_pkg::MAX_COLS_DEF,
  parameter int HEIGHT_BITS = gtr_pkg::HEIGHT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic [gtr_pkg::ROW_W-1:0]          row,
  input  logic [gtr_pkg::COL_W-1:0]          col,
  input  logic [gtr_pkg::HEIGHT_W-1:0]       height,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               pacific_reached,
  output logic                               atlantic_reached,
  output logic                               both_reached,
  output logic                               out_of_range,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gtr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gtr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SZR = $clog2(MAX_ROWS + 1);
  localparam int SZC = $clog2(MAX_COLS + 1);

  logic [gtr_pkg::CFG_DATA_W-1:0] num_rows;
  logic [gtr_pkg::CFG_DATA_W-1:0] num_cols;
  logic [SZR-1:0]                 rows_used;
  logic [SZC-1:0]                 cols_used;
  gtr_pkg::result_t               res;

  // Take configuration words at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= gtr_pkg::CFG_SIZE_RESET;
      num_cols <= gtr_pkg::CFG_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gtr_pkg::CFG_NUM_ROWS: num_rows <= cfg_data;
        gtr_pkg::CFG_NUM_COLS: num_cols <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Clamp the sizes in use to at least one and at most the physical grid
  always_comb begin
    if (num_rows == '0) begin
      rows_used = SZR'(1);
    end else if (32'(num_rows) > MAX_ROWS) begin
      rows_used = SZR'(MAX_ROWS);
    end else begin
      rows_used = SZR'(num_rows);
    end
    if (num_cols == '0) begin
      cols_used = SZC'(1);
    end else if (32'(num_cols) > MAX_COLS) begin
      cols_used = SZC'(MAX_COLS);
    end else begin
      cols_used = SZC'(num_cols);
    end
  end

  gtr_walk #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .rows_used (rows_used),
    .cols_used (cols_used),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .row       (row),
    .col       (col),
    .height    (height),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Unpack the result word
  assign pacific_reached  = res.pacific_reached;
  assign atlantic_reached = res.atlantic_reached;
  assign both_reached     = res.both_reached;
  assign out_of_range     = res.out_of_range;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for grid_two_edge_reachability_core
// Drives height writes and reachability queries through the input channel and
// sets the grid size through the register channel. A scoreboard keeps a copy
// of the height map and the size registers. For each accepted query in range it
// walks the downhill region itself; for every accepted word it queues the expected
// flags. Results are checked in order. Idle gaps and output stalls are random outside burst phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_ROWS       = gtr_pkg::MAX_ROWS_DEF;
  localparam int MAX_COLS       = gtr_pkg::MAX_COLS_DEF;
  localparam int CELLS          = MAX_ROWS * MAX_COLS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 20;
  localparam int REPORT_LIMIT   = 10;

  // Indexes past the register list; the core must ignore them
  localparam logic [gtr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [gtr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  // Keep the height map and sizes, predict the flags of every word
  class edge_reach_board;
    logic [gtr_pkg::HEIGHT_W-1:0]   heights [CELLS];
    bit                             seen [CELLS];
    int                             walk_todo [$];
    logic [gtr_pkg::CFG_DATA_W-1:0] rows_reg;
    logic [gtr_pkg::CFG_DATA_W-1:0] cols_reg;
    gtr_pkg::result_t               flags_due [$];
    int                             mismatches;

    function new();
      rows_reg   = gtr_pkg::CFG_SIZE_RESET;
      cols_reg   = gtr_pkg::CFG_SIZE_RESET;
      mismatches = 0;
    endfunction

    // Clamp a size register to 1..limit
    function int clamp_size(logic [gtr_pkg::CFG_DATA_W-1:0] v, int limit);
      if (v < 1) return 1;
      if (v > limit) return limit;
      return int'(v);
    endfunction

    function int rows_in_use();
      return clamp_size(rows_reg, MAX_ROWS);
    endfunction

    function int cols_in_use();
      return clamp_size(cols_reg, MAX_COLS);
    endfunction

    function void take_config(logic [gtr_pkg::CFG_INDEX_W-1:0] idx,
                              logic [gtr_pkg::CFG_DATA_W-1:0] data);
      if (idx == gtr_pkg::CFG_NUM_ROWS) rows_reg = data;
      else if (idx == gtr_pkg::CFG_NUM_COLS) cols_reg = data;
    endfunction

    // Mark and stack a neighbour that is not higher than the current cell
    function void spread(int idx, logic [gtr_pkg::HEIGHT_W-1:0] cur_h);
      if (seen[idx]) return;
      if (heights[idx] > cur_h) return;
      seen[idx] = 1'b1;
      walk_todo = {walk_todo, idx};
    endfunction

    // Apply one accepted word and queue the flags it must produce
    function void take_word(logic op, logic [gtr_pkg::ROW_W-1:0] r,
                            logic [gtr_pkg::COL_W-1:0] c,
                            logic [gtr_pkg::HEIGHT_W-1:0] h);
      gtr_pkg::result_t             flags;
      int                           nr;
      int                           nc;
      int                           idx;
      int                           cr;
      int                           cc;
      logic [gtr_pkg::HEIGHT_W-1:0] ch;
      nr    = rows_in_use();
      nc    = cols_in_use();
      flags = '0;
      flags.out_of_range = (r >= nr) || (c >= nc);
      if (op == gtr_pkg::OP_WRITE) begin
        heights[r * MAX_COLS + c] = h;
      end else if (!flags.out_of_range) begin
        foreach (seen[i]) seen[i] = 1'b0;
        walk_todo.delete();
        seen[r * MAX_COLS + c] = 1'b1;
        walk_todo = {walk_todo, int'(r * MAX_COLS + c)};
        while (walk_todo.size() > 0) begin
          idx = walk_todo.pop_back();
          cr  = idx / MAX_COLS;
          cc  = idx % MAX_COLS;
          ch  = heights[idx];
          if (cr == nr - 1 || cc == nc - 1) flags.atlantic_reached = 1'b1;
          if (cr == 0 || cc == 0) flags.pacific_reached = 1'b1;
          if (cr > 0) spread(idx - MAX_COLS, ch);
          if (cr + 1 < nr) spread(idx + MAX_COLS, ch);
          if (cc + 1 < nc) spread(idx + 1, ch);
          if (cc > 0) spread(idx - 1, ch);
        end
      end
      flags.both_reached = flags.pacific_reached && flags.atlantic_reached;
      flags_due = {flags_due, flags};
    endfunction

    // Compare one result word with the oldest expectation
    function void match_flags(gtr_pkg::result_t got);
      gtr_pkg::result_t want;
      if (flags_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result word pac=%0b atl=%0b both=%0b oor=%0b",
                   got.pacific_reached, got.atlantic_reached, got.both_reached,
                   got.out_of_range);
        return;
      end
      want = flags_due.pop_front();
      if (got.pacific_reached !== want.pacific_reached ||
          got.atlantic_reached !== want.atlantic_reached ||
          got.both_reached !== want.both_reached ||
          got.out_of_range !== want.out_of_range) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result mismatch: expected pac=%0b atl=%0b both=%0b oor=%0b,",
                   want.pacific_reached, want.atlantic_reached, want.both_reached,
                   want.out_of_range,
                   " got pac=%0b atl=%0b both=%0b oor=%0b",
                   got.pacific_reached, got.atlantic_reached,
                   got.both_reached, got.out_of_range);
      end
    endfunction

    function int pending();
      return flags_due.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic                            opcode;
  logic [gtr_pkg::ROW_W-1:0]       row;
  logic [gtr_pkg::COL_W-1:0]       col;
  logic [gtr_pkg::HEIGHT_W-1:0]    height;
  logic                            out_valid;
  logic                            out_stall;
  logic                            pacific_reached;
  logic                            atlantic_reached;
  logic                            both_reached;
  logic                            out_of_range;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [gtr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [gtr_pkg::CFG_DATA_W-1:0]  cfg_data;

  edge_reach_board board;
  bit              burst;
  int              results_seen;
  int              idle_cycles;
  bit              cell_written [CELLS];

  grid_two_edge_reachability_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .row              (row),
    .col              (col),
    .height           (height),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pacific_reached  (pacific_reached),
    .atlantic_reached (atlantic_reached),
    .both_reached     (both_reached),
    .out_of_range     (out_of_range),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Note accepted words, check results, watch for a hung core
  always @(posedge clk) begin : monitor
    gtr_pkg::result_t got;
    bit               took;
    took = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.pacific_reached  = pacific_reached;
        got.atlantic_reached = atlantic_reached;
        got.both_reached     = both_reached;
        got.out_of_range     = out_of_range;
        board.match_flags(got);
        results_seen++;
        took = 1'b1;
      end
      if (in_valid && !in_stall) begin
        board.take_word(opcode, row, col, height);
        took = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        board.take_config(cfg_index, cfg_data);
        took = 1'b1;
      end
    end
    idle_cycles = took ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // After each result, stall the output channel at random, except in burst phases
  initial begin : result_stall
    int left;
    int seen_count;
    left       = 0;
    seen_count = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (results_seen != seen_count) begin
        seen_count = results_seen;
        left       = burst ? 0 : $urandom_range(0, 10);
      end
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Drive one input word and hold it until taken
  task automatic send_word(logic op, int r, int c, logic [gtr_pkg::HEIGHT_W-1:0] h);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    row      <= gtr_pkg::ROW_W'(r);
    col      <= gtr_pkg::COL_W'(c);
    height   <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_cell(int r, int c, logic [gtr_pkg::HEIGHT_W-1:0] h);
    cell_written[r * MAX_COLS + c] = 1'b1;
    send_word(gtr_pkg::OP_WRITE, r, c, h);
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
  endtask

  task automatic set_reg(logic [gtr_pkg::CFG_INDEX_W-1:0] idx,
                         logic [gtr_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small heights so that plateaus and downhill paths show up
  function automatic logic [gtr_pkg::HEIGHT_W-1:0] pick_height();
    if ($urandom_range(0, 9) == 0) return gtr_pkg::HEIGHT_W'($urandom);
    return gtr_pkg::HEIGHT_W'($urandom_range(0, 3));
  endfunction

  // Resize the grid, fill the unwritten cells, then run random words
  task automatic run_phase(logic [gtr_pkg::CFG_DATA_W-1:0] rows_val,
                           logic [gtr_pkg::CFG_DATA_W-1:0] cols_val,
                           int count, bit fast);
    int nr;
    int nc;
    int pick;
    int r;
    int c;
    drain();
    burst = fast;
    set_reg(gtr_pkg::CFG_NUM_ROWS, rows_val);
    set_reg(gtr_pkg::CFG_NUM_COLS, cols_val);
    nr = board.rows_in_use();
    nc = board.cols_in_use();
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++)
        if (!cell_written[i * MAX_COLS + j]) write_cell(i, j, pick_height());
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_word(gtr_pkg::OP_QUERY, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                  gtr_pkg::HEIGHT_W'($urandom));
      end else if (pick < 55) begin
        // address a cell past the last row or the last column
        if (nr < MAX_ROWS && (nc == MAX_COLS || $urandom_range(0, 1) == 1)) begin
          r = $urandom_range(nr, MAX_ROWS - 1);
          c = $urandom_range(0, MAX_COLS - 1);
        end else begin
          r = $urandom_range(0, MAX_ROWS - 1);
          c = $urandom_range(nc, MAX_COLS - 1);
        end
        send_word(gtr_pkg::OP_QUERY, r, c, gtr_pkg::HEIGHT_W'($urandom));
      end else if (pick < 85) begin
        write_cell($urandom_range(0, nr - 1), $urandom_range(0, nc - 1), pick_height());
      end else if (pick < 95) begin
        write_cell($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_COLS - 1),
                   gtr_pkg::HEIGHT_W'($urandom));
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    board        = new();
    burst        = 1'b0;
    results_seen = 0;
    idle_cycles  = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = gtr_pkg::OP_WRITE;
    row          = '0;
    col          = '0;
    height       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = gtr_pkg::CFG_NUM_ROWS;
    cfg_data     = '0;
    foreach (cell_written[i]) cell_written[i] = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single cell grid: zero rows clamps to one, spare indexes do nothing
    set_reg(gtr_pkg::CFG_NUM_ROWS, 6'd0);
    set_reg(gtr_pkg::CFG_NUM_COLS, 6'd1);
    set_reg(CFG_SPARE_2, 6'd5);
    set_reg(CFG_SPARE_3, 6'd63);
    write_cell(0, 0, 16'hFFFF);
    send_word(gtr_pkg::OP_QUERY, 0, 0, 16'h0000);
    send_word(gtr_pkg::OP_QUERY, 0, 5, 16'hFFFF);
    send_word(gtr_pkg::OP_QUERY, 31, 31, 16'h0000);
    write_cell(31, 31, 16'h0000);
    write_cell(0, 0, 16'h0000);

    // 3x3 ring at 9 around a pit: walk stays home, then leaks west, then east
    drain();
    set_reg(gtr_pkg::CFG_NUM_ROWS, 6'd3);
    set_reg(gtr_pkg::CFG_NUM_COLS, 6'd3);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        write_cell(i, j, (i == 1 && j == 1) ? 16'd0 : 16'd9);
    send_word(gtr_pkg::OP_QUERY, 1, 1, 16'h0000);
    write_cell(1, 1, 16'd5);
    write_cell(1, 0, 16'd1);
    send_word(gtr_pkg::OP_QUERY, 1, 1, 16'h0000);
    write_cell(1, 0, 16'd9);
    write_cell(1, 2, 16'd1);
    send_word(gtr_pkg::OP_QUERY, 1, 1, 16'h0000);
    send_word(gtr_pkg::OP_QUERY, 0, 0, 16'h0000);
    send_word(gtr_pkg::OP_QUERY, 3, 1, 16'h0000);

    // Random phases over several sizes, extremes and clamped values included
    run_phase(6'd4, 6'd4, 12, 1'b0);
    run_phase(6'd1, 6'd33, 12, 1'b1);
    run_phase(6'd40, 6'd1, 12, 1'b0);
    run_phase(6'd5, 6'd6, 12, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/gtr_pkg.sv
rtl/core/gtr_ram.sv
rtl/core/gtr_walk.sv
rtl/core/grid_two_edge_reachability_core.sv
tb/tb.sv
